// ===== rtl/core/multi_key_debounce_autorepeat_unit_defines.svh =====
// Assertion helpers for the key debouncer. The module that uses them
// provides i_clk and i_rst_n.
`ifndef MULTI_KEY_DEBOUNCE_AUTOREPEAT_UNIT_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_AUTOREPEAT_UNIT_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define MKDA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define MKDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mkda_pkg.sv =====
package mkda_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 4;
    localparam int HOLD_W     = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP  = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0]  PRESS_THR_RST    = 4'd7;
    localparam logic [THR_W-1:0]  RELEASE_THR_RST  = 4'd1;
    localparam logic [HOLD_W-1:0] HOLD_TIMEOUT_RST = 16'd100;
    localparam logic [HOLD_W-1:0] REPEAT_GAP_RST   = 16'd20;

    typedef enum logic [1:0] {
        PH_OFF     = 2'd0,
        PH_PUSH    = 2'd1,
        PH_ON      = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [THR_W-1:0]  press_thr;
        logic [THR_W-1:0]  release_thr;
        logic [HOLD_W-1:0] hold_timeout;
        logic [HOLD_W-1:0] repeat_gap;
    } t_cfg;

    // per-key update from the shared step unit
    typedef struct packed {
        t_phase            phase;
        logic [HOLD_W-1:0] hold;
        logic              emit;
        logic              rep;
    } t_step_res;

endpackage

// ===== rtl/core/mkda_in_if.sv =====
interface mkda_in_if #(
    parameter int NUM_KEYS = 5
);
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

// ===== rtl/core/mkda_out_if.sv =====
interface mkda_out_if #(
    parameter int KEY_W = 3
);
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_number;
    logic             is_repeat;
    logic             last_event;

    modport source (output valid, output key_number, output is_repeat, output last_event,
                    input ready);
    modport sink   (input valid, input key_number, input is_repeat, input last_event,
                    output ready);
endinterface

// ===== rtl/core/mkda_key_step.sv =====
module mkda_key_step
    import mkda_pkg::*;
#(
    parameter int HISTORY_BITS = 8
) (
    input  t_cfg                     i_cfg,
    input  logic                     i_level,
    input  logic [HISTORY_BITS-1:0]  i_hist,
    input  t_phase                   i_phase,
    input  logic [HOLD_W-1:0]        i_hold,
    output logic [HISTORY_BITS-1:0]  o_hist,
    output t_step_res                o_res
);

    localparam int CNT_W = $clog2(HISTORY_BITS + 1);
    localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

    logic [CNT_W-1:0] w_ones;
    logic [CMP_W-1:0] w_ones_x;
    logic             w_pressed;
    logic             w_released;
    logic             w_timed_out;
    logic [HOLD_W-1:0] w_reload;

    // active-low pin: shift in the inverted level
    assign o_hist = {i_hist[HISTORY_BITS-2:0], ~i_level};

    always_comb begin
        w_ones = '0;
        for (int b = 0; b < HISTORY_BITS; b++) begin
            w_ones = w_ones + CNT_W'(o_hist[b]);
        end
    end

    assign w_ones_x    = CMP_W'(w_ones);
    assign w_pressed   = w_ones_x >= CMP_W'(i_cfg.press_thr);
    assign w_released  = w_ones_x <= CMP_W'(i_cfg.release_thr);
    assign w_timed_out = i_hold >= i_cfg.hold_timeout;
    assign w_reload    = (i_cfg.hold_timeout > i_cfg.repeat_gap) ?
                         (i_cfg.hold_timeout - i_cfg.repeat_gap) : '0;

    always_comb begin
        o_res.phase = i_phase;
        o_res.hold  = i_hold;
        o_res.emit  = 1'b0;
        o_res.rep   = 1'b0;
        priority if (w_pressed) begin
            unique case (i_phase)
                PH_OFF, PH_RELEASE: begin
                    o_res.phase = PH_PUSH;
                    o_res.emit  = 1'b1;
                end
                PH_PUSH: begin
                    o_res.phase = PH_ON;
                end
                PH_ON: begin
                    if (w_timed_out) begin
                        o_res.hold = w_reload;
                        o_res.emit = 1'b1;
                        o_res.rep  = 1'b1;
                    end else begin
                        o_res.hold = i_hold + HOLD_W'(1);
                    end
                end
            endcase
        end else if (w_released) begin
            unique case (i_phase)
                PH_PUSH, PH_ON: o_res.phase = PH_RELEASE;
                PH_RELEASE:     o_res.phase = PH_OFF;
                PH_OFF:         o_res.phase = PH_OFF;
            endcase
        end else begin
            // between thresholds: key state kept
        end
    end

endmodule

// ===== rtl/core/multi_key_debounce_autorepeat_unit.sv =====
// Channel | Dir | Payload                              | Moves
// i_key   | in  | key_levels[NUM_KEYS-1:0]             | one scan tick per request
// o_evt   | out | key_number, is_repeat, last_event    | one key event per request
//
// A tick runs through the accept in idle, each key in turn through the shared
// step unit, then a flush of the held-back final event.
// An event found while another is pending stalls the scan for every cycle the
// output register stays full; the flush waits for the register in the same way.
// Synchronous active-low reset clears key state, config to defaults, no events.
`include "multi_key_debounce_autorepeat_unit_defines.svh"

module multi_key_debounce_autorepeat_unit
    import mkda_pkg::*;
#(
    parameter int NUM_KEYS     = 5,
    parameter int HISTORY_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mkda_in_if.sink               i_key,
    mkda_out_if.source            o_evt
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_W = $clog2(NUM_KEYS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                  r_state;
    t_cfg                    r_cfg;
    logic [NUM_KEYS-1:0]     r_levels;
    logic [IDX_W-1:0]        r_idx;

    // per-key state, one entry touched per cycle while the scan runs unstalled
    logic [HISTORY_BITS-1:0] r_hist  [NUM_KEYS];
    t_phase                  r_phase [NUM_KEYS];
    logic [HOLD_W-1:0]       r_hold  [NUM_KEYS];

    // pending event: held until we know whether a later key also fires
    logic                    r_pend_valid;
    logic [KEY_W-1:0]        r_pend_key;
    logic                    r_pend_rep;

    logic                    r_out_valid;
    logic [KEY_W-1:0]        r_out_key;
    logic                    r_out_rep;
    logic                    r_out_last;

    logic [HISTORY_BITS-1:0] w_hist_nx;
    t_step_res               w_res;
    logic                    w_out_free;
    logic                    w_stall;
    logic [KEY_W-1:0]        w_key_num;

    mkda_key_step #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_level (r_levels[r_idx]),
        .i_hist  (r_hist[r_idx]),
        .i_phase (r_phase[r_idx]),
        .i_hold  (r_hold[r_idx]),
        .o_hist  (w_hist_nx),
        .o_res   (w_res)
    );

    assign w_out_free = !r_out_valid || o_evt.ready;
    // the scan stalls only when an event finds one pending and the output register full
    assign w_stall    = w_res.emit && r_pend_valid && !w_out_free;
    assign w_key_num  = KEY_W'(r_idx) + KEY_W'(1);

    assign i_key.ready      = (r_state == ST_IDLE);
    assign o_evt.valid      = r_out_valid;
    assign o_evt.key_number = r_out_key;
    assign o_evt.is_repeat  = r_out_rep;
    assign o_evt.last_event = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= ST_IDLE;
            r_idx              <= '0;
            r_pend_valid       <= 1'b0;
            r_out_valid        <= 1'b0;
            r_cfg.press_thr    <= PRESS_THR_RST;
            r_cfg.release_thr  <= RELEASE_THR_RST;
            r_cfg.hold_timeout <= HOLD_TIMEOUT_RST;
            r_cfg.repeat_gap   <= REPEAT_GAP_RST;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_hist[k]  <= '0;
                r_phase[k] <= PH_OFF;
                r_hold[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PRESS_THR:    r_cfg.press_thr    <= i_cfg_data[THR_W-1:0];
                    CFG_RELEASE_THR:  r_cfg.release_thr  <= i_cfg_data[THR_W-1:0];
                    CFG_HOLD_TIMEOUT: r_cfg.hold_timeout <= i_cfg_data[HOLD_W-1:0];
                    CFG_REPEAT_GAP:   r_cfg.repeat_gap   <= i_cfg_data[HOLD_W-1:0];
                endcase
            end

            if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_key.valid) begin
                        r_levels <= i_key.key_levels;
                        r_idx    <= '0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!w_stall) begin
                        r_hist[r_idx]  <= w_hist_nx;
                        r_phase[r_idx] <= w_res.phase;
                        r_hold[r_idx]  <= w_res.hold;
                        if (w_res.emit) begin
                            // earlier event is now known not to be the last
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_out_key   <= r_pend_key;
                                r_out_rep   <= r_pend_rep;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_key   <= w_key_num;
                            r_pend_rep   <= w_res.rep;
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_key    <= r_pend_key;
                        r_out_rep    <= r_pend_rep;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `MKDA_ASSERT_NEXT(a_accept_starts_scan, i_key.valid && i_key.ready, r_state == ST_SCAN, "tick accepted but scan not started")
    `MKDA_ASSERT_SAME(a_idle_no_pending, r_state == ST_IDLE, !r_pend_valid, "pending event left over in idle")
    `MKDA_ASSERT_SAME(a_idx_in_range, r_state == ST_SCAN, 32'(r_idx) < NUM_KEYS, "key index out of range")
    `MKDA_ASSERT_SAME(a_key_nonzero, r_out_valid, r_out_key != '0, "event with key number zero")

endmodule

// ===== tb/sv/multi_key_debounce_autorepeat_unit_tb.sv =====
module multi_key_debounce_autorepeat_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mkda_pkg::*;

    localparam int NUM_KEYS     = 5;
    localparam int HISTORY_BITS = 8;
    localparam int KEY_W        = 3;

    // One tick walks the keys one per cycle, unless stalled, plus a flush; allow twice that.
    localparam int SETTLE_CYCLES  = 2 * (NUM_KEYS + 1) + 4;
    // Long receiver hold-off, so the event register fills and the scan stalls.
    localparam int HOLDOFF_CYCLES = 400;
    // About 500 ticks, up to five events each, with half the cycles stalled on
    // either side; several times the slowest correct run.
    localparam int CYCLE_LIMIT    = 250000;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [KEY_W-1:0] key_number;
        logic             is_repeat;
        logic             last_event;
    } t_key_event;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mkda_in_if  #(.NUM_KEYS(NUM_KEYS)) key_if ();
    mkda_out_if #(.KEY_W(KEY_W))       evt_if ();

    multi_key_debounce_autorepeat_unit #(
        .NUM_KEYS     (NUM_KEYS),
        .HISTORY_BITS (HISTORY_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key      (key_if.sink),
        .o_evt      (evt_if.source)
    );

    // ------------------------------------------------------------------
    // Debouncer model: its own copy of the registers and per-key state
    // ------------------------------------------------------------------
    t_cfg                    cfg_model;
    logic [HISTORY_BITS-1:0] key_history [NUM_KEYS];
    t_phase                  model_phase [NUM_KEYS];
    logic [HOLD_W-1:0]       key_hold    [NUM_KEYS];

    t_key_event expected_events [$];

    int  error_count;
    int  cycle_count;
    int  src_idle_pct;
    int  sink_stall_pct;
    bit  holdoff_request;
    bit  holdoff_active;

    // random key activity: keys the virtual user is holding down
    logic [NUM_KEYS-1:0] held_keys;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles, %0d events outstanding",
                     $time, cycle_count, expected_events.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic void reset_model();
        cfg_model = '{press_thr: PRESS_THR_RST, release_thr: RELEASE_THR_RST,
                      hold_timeout: HOLD_TIMEOUT_RST, repeat_gap: REPEAT_GAP_RST};
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_history[k] = '0;
            model_phase[k] = PH_OFF;
            key_hold[k]    = '0;
        end
    endfunction

    // One scan tick: shift the pressed bits in, hold each key's count to the
    // thresholds and step its machine. Events queue up in key order, last one marked.
    function automatic void predict_tick(input logic [NUM_KEYS-1:0] levels);
        int         ones;
        bit         fire;
        bit         hold_repeat;
        t_key_event tick_events [$];
        t_key_event evt;
        for (int k = 0; k < NUM_KEYS; k++) begin
            fire        = 1'b0;
            hold_repeat = 1'b0;
            key_history[k] = {key_history[k][HISTORY_BITS-2:0], ~levels[k]};
            ones = $countones(key_history[k]);
            // pressed test wins where the two thresholds overlap
            if (ones >= int'(cfg_model.press_thr)) begin
                case (model_phase[k])
                    PH_OFF, PH_RELEASE: begin
                        model_phase[k] = PH_PUSH;
                        fire           = 1'b1;
                    end
                    PH_PUSH: model_phase[k] = PH_ON;
                    default: begin
                        if (key_hold[k] >= cfg_model.hold_timeout) begin
                            // reload floors at zero when the gap exceeds the timeout
                            key_hold[k] = (cfg_model.hold_timeout > cfg_model.repeat_gap) ?
                                          cfg_model.hold_timeout - cfg_model.repeat_gap : '0;
                            fire        = 1'b1;
                            hold_repeat = 1'b1;
                        end else begin
                            key_hold[k] = key_hold[k] + 1'b1;
                        end
                    end
                endcase
            end else if (ones <= int'(cfg_model.release_thr)) begin
                // hold count deliberately left alone on release
                case (model_phase[k])
                    PH_PUSH, PH_ON: model_phase[k] = PH_RELEASE;
                    PH_RELEASE:     model_phase[k] = PH_OFF;
                    default: ;
                endcase
            end
            if (fire) begin
                evt.key_number = KEY_W'(k + 1);
                evt.is_repeat  = hold_repeat;
                evt.last_event = 1'b0;
                tick_events.push_back(evt);
            end
        end
        if (tick_events.size() > 0)
            tick_events[tick_events.size() - 1].last_event = 1'b1;
        foreach (tick_events[i])
            expected_events.push_back(tick_events[i]);
    endfunction

    // ------------------------------------------------------------------
    // Event checker: every accepted event against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_key_event want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected event, key", 16'(evt_if.key_number), 16'd0);
            end else begin
                want = expected_events.pop_front();
                if (evt_if.key_number !== want.key_number)
                    report_mismatch("key_number", 16'(evt_if.key_number), 16'(want.key_number));
                if (evt_if.is_repeat !== want.is_repeat)
                    report_mismatch("is_repeat", 16'(evt_if.is_repeat), 16'(want.is_repeat));
                if (evt_if.last_event !== want.last_event)
                    report_mismatch("last_event", 16'(evt_if.last_event), 16'(want.last_event));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off when requested
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        evt_if.ready <= !holdoff_active && ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        holdoff_active = 1'b0;
        wait (holdoff_request);
        holdoff_active = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        holdoff_active = 1'b0;
    end

    // 0: no idling, 1: sender idles half the time, 2: receiver stalls half
    // the time, 3: both at fifteen percent
    task automatic set_idling(input int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 50; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 50; end
            default: begin src_idle_pct = 15; sink_stall_pct = 15; end
        endcase
    endtask

    // Offers one tick and returns at the edge it is taken. Valid is left high
    // so that back-to-back requests need no second assignment in one step.
    task automatic send_tick(input logic [NUM_KEYS-1:0] levels);
        while ($urandom_range(99) < src_idle_pct) begin
            key_if.valid      <= 1'b0;
            key_if.key_levels <= NUM_KEYS'($urandom);
            @(posedge i_clk);
        end
        key_if.valid      <= 1'b1;
        key_if.key_levels <= levels;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        predict_tick(levels);
    endtask

    // Lowers valid, waits for every predicted event, then lets any tick
    // without events run out of the pipeline.
    task automatic drain();
        key_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Threshold writes carry random junk above bit 3, which the block drops.
    task automatic write_config(input logic [THR_W-1:0] press_thr, input logic [THR_W-1:0] rel_thr,
                                input logic [HOLD_W-1:0] timeout, input logic [HOLD_W-1:0] gap);
        drain();
        cfg_write(CFG_PRESS_THR,    {12'($urandom), press_thr});
        cfg_write(CFG_RELEASE_THR,  {12'($urandom), rel_thr});
        cfg_write(CFG_HOLD_TIMEOUT, timeout);
        cfg_write(CFG_REPEAT_GAP,   gap);
        i_cfg_we <= 1'b0;
        cfg_model.press_thr    = press_thr;
        cfg_model.release_thr  = rel_thr;
        cfg_model.hold_timeout = timeout;
        cfg_model.repeat_gap   = gap;
    endtask

    // Mostly deliberate presses and releases, with contact bounce on top
    // and the odd tick of pure noise.
    function automatic logic [NUM_KEYS-1:0] next_levels();
        logic [NUM_KEYS-1:0] levels;
        for (int k = 0; k < NUM_KEYS; k++)
            if ($urandom_range(11) == 0) held_keys[k] = ~held_keys[k];
        levels = ~held_keys;
        for (int k = 0; k < NUM_KEYS; k++)
            if ($urandom_range(19) == 0) levels[k] = ~levels[k];
        if ($urandom_range(9) == 0) levels = NUM_KEYS'($urandom);
        return levels;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: an idle tick leaves keys off, then all five keys go
    // down together; the seventh tick held down presses every key at once.
    task automatic test_press_defaults();
        set_idling(0);
        send_tick('1);
        repeat (8) send_tick('0);
    endtask

    // Short timeout with a gap beyond it, so the reload floors at zero and
    // repeats come every other tick; then release and drop back to off.
    task automatic test_repeat_and_release();
        write_config(4'd7, 4'd1, 16'd1, 16'd3);
        set_idling(3);
        repeat (4) send_tick('0);
        repeat (8) send_tick('1);
    endtask

    // Press threshold of zero: every key reads as pressed with nothing held,
    // and the hold counts carried over from before pick up where they were.
    task automatic test_press_threshold_zero();
        write_config(4'd0, 4'd1, 16'd1, 16'd3);
        set_idling(2);
        repeat (3) send_tick('1);
    endtask

    task automatic run_segment(input int mode, input int ticks);
        set_idling(mode);
        repeat (ticks) send_tick(next_levels());
    endtask

    // Random key traffic through a range of settings, the extremes among
    // them: unreachable thresholds, both thresholds overlapping, zero and
    // full-scale timeout and gap.
    task automatic test_random_traffic();
        held_keys = '0;
        write_config(4'd7, 4'd1, 16'd12, 16'd4);
        run_segment(0, 55);
        write_config(4'd0, 4'd0, 16'd0, 16'd0);
        run_segment(1, 55);
        write_config(4'd8, 4'd8, 16'd3, 16'd1);
        run_segment(2, 55);
        write_config(4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
        run_segment(3, 55);
        write_config(4'd4, 4'd3, 16'd10, 16'hFFFF);
        run_segment(0, 55);
        write_config(4'd1, 4'd0, 16'hFFFF, 16'd0);
        run_segment(1, 55);
        write_config(4'd5, 4'd2, 16'd5, 16'd2);
        run_segment(2, 55);
        write_config(4'($urandom_range(0, 9)), 4'($urandom_range(0, 8)),
                     16'($urandom_range(0, 30)), 16'($urandom_range(0, 40)));
        run_segment(3, 55);
    endtask

    // Once on, every key repeats on every tick while the receiver holds off for a
    // long stretch: the event register fills and the scan input must stall.
    task automatic test_output_backpressure();
        write_config(4'd0, 4'd0, 16'd0, 16'd0);
        set_idling(0);
        holdoff_request = 1'b1;
        repeat (40) send_tick(next_levels());
    endtask

    initial begin
        error_count     = 0;
        cycle_count     = 0;
        holdoff_request = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        held_keys       = '0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_PRESS_THR;
        i_cfg_data        <= '0;
        key_if.valid      <= 1'b0;
        key_if.key_levels <= '1;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_press_defaults();
        test_repeat_and_release();
        test_press_threshold_zero();
        test_random_traffic();
        test_output_backpressure();
        drain();

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
